// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL modules; ccw_ctrl includes them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is applied
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/ccw_pkg.sv -----
// ---------------------------------------------------------------------------
// ccw_pkg
// Shared types and constants of the wraparound channel convolution unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ccw_pkg;

    // Default sizes of the stores
    localparam int MAX_PIXELS_DEF      = 4096;
    localparam int MAX_CHANNELS_DEF    = 4;
    localparam int MAX_KERNEL_SIDE_DEF = 5;

    // Configuration port widths
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    // Cycles to empty the tap pipeline before writeback
    localparam int DRAIN_CYCLES = 7;

    // Item operations
    typedef enum logic [1:0] {
        MODE_COEF_WR = 2'd0,
        MODE_PIX_WR  = 2'd1,
        MODE_RUN     = 2'd2,
        MODE_PIX_RD  = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_WIDTH     = 3'd0,
        CFG_IMG_HEIGHT    = 3'd1,
        CFG_NUM_CHANNELS  = 3'd2,
        CFG_CHANNEL_SEL   = 3'd3,
        CFG_KERNEL_WIDTH  = 3'd4,
        CFG_KERNEL_HEIGHT = 3'd5,
        CFG_CENTER_ROW    = 3'd6,
        CFG_CENTER_COL    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0] img_width;
        logic [12:0] img_height;
        logic [2:0]  num_channels;
        logic [1:0]  channel_sel;
        logic [2:0]  kernel_width;
        logic [2:0]  kernel_height;
        logic [2:0]  center_row;
        logic [2:0]  center_col;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [13:0]        address;
        logic signed [15:0] coef_value;
        logic [7:0]         pixel_value;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic tap_vld;
        logic tap_first;
        logic tap_last;
        logic wb_rd;
    } t_dp_ctl;

endpackage

`default_nettype wire

// ----- design/channel_convolution_wraparound_unit.sv -----
// ---------------------------------------------------------------------------
// channel_convolution_wraparound_unit
// 2D convolution of one interleaved image channel with wraparound borders.
// ---------------------------------------------------------------------------
// Coefficient writes, byte writes and byte reads do not raise busy: the
// result strobe comes in the cycle after start, so such items may be
// issued back to back. A run item holds busy through the check, the anchor
// reduction, the frame walk, the drain, the writeback and an end state: the
// frame walk issues one kernel tap per cycle through the single read port of
// the image memory, then a writeback pass copies one pixel per cycle from the
// result plane into the selected channel. A run with an illegal setup holds
// busy only through the check state. The done strobe comes in the first
// cycle with busy low. There is no clearing pass after reset; the receiver
// cannot stall, so every strobe is a delivered result.
// ---------------------------------------------------------------------------
`default_nettype none

module channel_convolution_wraparound_unit #(
    parameter int MAX_PIXELS      = ccw_pkg::MAX_PIXELS_DEF,
    parameter int MAX_CHANNELS    = ccw_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNEL_SIDE = ccw_pkg::MAX_KERNEL_SIDE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire ccw_pkg::t_item                 i_item,
    output logic                                busy,
    output logic                                o_res_vld,
    output ccw_pkg::t_res                       o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [ccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ccw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PAW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int COEF_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

    ccw_pkg::t_cfg    r_cfg;
    ccw_pkg::t_dp_ctl dp_ctl;
    logic             acc;
    logic [PAW-1:0]   row, col, pidx;
    logic [CAW-1:0]   cidx;
    logic [7:0]       read_data;
    logic             done;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_width     <= 13'd64;
            r_cfg.img_height    <= 13'd64;
            r_cfg.num_channels  <= 3'd3;
            r_cfg.channel_sel   <= 2'd0;
            r_cfg.kernel_width  <= 3'd3;
            r_cfg.kernel_height <= 3'd3;
            r_cfg.center_row    <= 3'd1;
            r_cfg.center_col    <= 3'd1;
        end else if (i_cfg_we) begin
            case (ccw_pkg::t_cfg_idx'(i_cfg_idx))
                ccw_pkg::CFG_IMG_WIDTH:     r_cfg.img_width     <= i_cfg_data;
                ccw_pkg::CFG_IMG_HEIGHT:    r_cfg.img_height    <= i_cfg_data;
                ccw_pkg::CFG_NUM_CHANNELS:  r_cfg.num_channels  <= i_cfg_data[2:0];
                ccw_pkg::CFG_CHANNEL_SEL:   r_cfg.channel_sel   <= i_cfg_data[1:0];
                ccw_pkg::CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= i_cfg_data[2:0];
                ccw_pkg::CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= i_cfg_data[2:0];
                ccw_pkg::CFG_CENTER_ROW:    r_cfg.center_row    <= i_cfg_data[2:0];
                ccw_pkg::CFG_CENTER_COL:    r_cfg.center_col    <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    ccw_ctrl #(
        .MAX_PIXELS      (MAX_PIXELS),
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_mode    (i_item.mode),
        .i_cfg     (r_cfg),
        .o_busy    (busy),
        .o_acc     (acc),
        .o_ctl     (dp_ctl),
        .o_row     (row),
        .o_col     (col),
        .o_cidx    (cidx),
        .o_pidx    (pidx),
        .o_res_vld (o_res_vld),
        .o_done    (done)
    );

    ccw_dp #(
        .MAX_PIXELS      (MAX_PIXELS),
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ctl       (dp_ctl),
        .i_row       (row),
        .i_col       (col),
        .i_cidx      (cidx),
        .i_pidx      (pidx),
        .i_acc       (acc),
        .i_item      (i_item),
        .o_read_data (read_data)
    );

    // Assemble the result item
    assign o_res.read_data = read_data;
    assign o_res.done_res  = done;

endmodule

`default_nettype wire

// ----- design/ccw_ram.sv -----
// ---------------------------------------------------------------------------
// ccw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/ccw_dp.sv -----
// ---------------------------------------------------------------------------
// ccw_dp
// Datapath: image, coefficient and result stores, tap address pipeline,
// multiply-accumulate, rounding and writeback.
// ---------------------------------------------------------------------------
`default_nettype none

module ccw_dp #(
    parameter int MAX_PIXELS      = ccw_pkg::MAX_PIXELS_DEF,
    parameter int MAX_CHANNELS    = ccw_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNEL_SIDE = ccw_pkg::MAX_KERNEL_SIDE_DEF,
    localparam int PAW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int COEF_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE,
    localparam int CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ccw_pkg::t_cfg    i_cfg,
    input  wire ccw_pkg::t_dp_ctl i_ctl,
    input  wire logic [PAW-1:0]   i_row,
    input  wire logic [PAW-1:0]   i_col,
    input  wire logic [CAW-1:0]   i_cidx,
    input  wire logic [PAW-1:0]   i_pidx,
    input  wire logic             i_acc,
    input  wire ccw_pkg::t_item   i_item,
    output logic      [7:0]       o_read_data
);

    localparam int IMG_DEPTH = MAX_PIXELS * MAX_CHANNELS;
    localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int PROD_W = 25;
    localparam int ACC_W = PROD_W + CAW + 1;

    // Item decode
    logic [31:0]    in_addr;
    logic           img_in_rng;
    logic           coef_in_rng;
    logic           pix_wr;
    logic           pix_rd;
    logic           coef_wr;

    assign in_addr     = 32'(i_item.address);
    assign img_in_rng  = in_addr < 32'(IMG_DEPTH);
    assign coef_in_rng = in_addr < 32'(COEF_DEPTH);
    assign pix_wr  = i_acc && (i_item.mode == ccw_pkg::MODE_PIX_WR) && img_in_rng;
    assign pix_rd  = i_acc && (i_item.mode == ccw_pkg::MODE_PIX_RD) && img_in_rng;
    assign coef_wr = i_acc && (i_item.mode == ccw_pkg::MODE_COEF_WR) && coef_in_rng;

    // Pipeline registers
    logic                     r1_vld, r2_vld, r3_vld, r4_vld, r5_fin;
    logic                     r1_first, r2_first, r3_first, r4_first;
    logic                     r1_last, r2_last, r3_last, r4_last;
    logic [PAW-1:0]           r1_pidx, r2_pidx, r3_pidx, r4_pidx, r5_pidx;
    logic [CAW-1:0]           r1_cidx, r2_cidx;
    logic [PAW-1:0]           r1_lin;
    logic [IAW-1:0]           r2_addr;
    logic signed [PROD_W-1:0] r4_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_wb_vld;
    logic [IAW-1:0]           r_wb_addr;
    logic                     r_rd_ok;

    logic [PAW+12:0]          lin_prod;
    logic [IAW+2:0]           tap_addr;
    logic [IAW+2:0]           wb_addr;
    logic [7:0]               img_dout;
    logic [15:0]              coef_dout;
    logic [7:0]               res_dout;
    logic [7:0]               res_byte;
    logic signed [ACC_W-1:0]  rnd_sum;

    assign lin_prod = (PAW+13)'(i_row) * (PAW+13)'(i_cfg.img_width) + (PAW+13)'(i_col);
    assign tap_addr = (IAW+3)'(r1_lin) * (IAW+3)'(i_cfg.num_channels)
                    + (IAW+3)'(i_cfg.channel_sel);
    assign wb_addr  = (IAW+3)'(i_pidx) * (IAW+3)'(i_cfg.num_channels)
                    + (IAW+3)'(i_cfg.channel_sel);

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r5_fin   <= 1'b0;
            r_wb_vld <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            r1_vld   <= i_ctl.tap_vld;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r4_vld   <= r3_vld;
            r5_fin   <= r4_vld && r4_last;
            r_wb_vld <= i_ctl.wb_rd;
            if (i_acc) begin
                r_rd_ok <= pix_rd;
            end
        end
    end

    // Advance the tap payload: address, fetch, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r1_lin   <= PAW'(lin_prod);
        r1_first <= i_ctl.tap_first;
        r1_last  <= i_ctl.tap_last;
        r1_pidx  <= i_pidx;
        r1_cidx  <= i_cidx;

        r2_addr  <= IAW'(tap_addr);
        r2_first <= r1_first;
        r2_last  <= r1_last;
        r2_pidx  <= r1_pidx;
        r2_cidx  <= r1_cidx;

        r3_first <= r2_first;
        r3_last  <= r2_last;
        r3_pidx  <= r2_pidx;

        r4_prod  <= PROD_W'(signed'(coef_dout)) * PROD_W'(signed'({1'b0, img_dout}));
        r4_first <= r3_first;
        r4_last  <= r3_last;
        r4_pidx  <= r3_pidx;

        if (r4_vld) begin
            r_acc <= r4_first ? ACC_W'(r4_prod) : r_acc + ACC_W'(r4_prod);
        end
        r5_pidx <= r4_pidx;

        r_wb_addr <= IAW'(wb_addr);
    end

    // Round half away from zero, clamp to a byte
    assign rnd_sum = (r_acc + ACC_W'(2048)) >>> 12;
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            res_byte = 8'd0;
        end else if (rnd_sum > ACC_W'(255)) begin
            res_byte = 8'd255;
        end else begin
            res_byte = rnd_sum[7:0];
        end
    end

    ccw_ram #(.WIDTH(8), .DEPTH(IMG_DEPTH)) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_vld || pix_wr),
        .i_waddr (r_wb_vld ? r_wb_addr : in_addr[IAW-1:0]),
        .i_wdata (r_wb_vld ? res_dout : i_item.pixel_value),
        .i_re    (r2_vld || pix_rd),
        .i_raddr (r2_vld ? r2_addr : in_addr[IAW-1:0]),
        .o_rdata (img_dout)
    );

    ccw_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_wr),
        .i_waddr (in_addr[CAW-1:0]),
        .i_wdata (i_item.coef_value),
        .i_re    (r2_vld),
        .i_raddr (r2_cidx),
        .o_rdata (coef_dout)
    );

    ccw_ram #(.WIDTH(8), .DEPTH(MAX_PIXELS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (r5_fin),
        .i_waddr (r5_pidx),
        .i_wdata (res_byte),
        .i_re    (i_ctl.wb_rd),
        .i_raddr (i_pidx),
        .o_rdata (res_dout)
    );

    assign o_read_data = r_rd_ok ? img_dout : 8'd0;

endmodule

`default_nettype wire

// ----- design/ccw_ctrl.sv -----
// ---------------------------------------------------------------------------
// ccw_ctrl
// Controller: item handshake, configuration check, frame and kernel walk,
// pipeline drain and writeback sequencing.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ccw_ctrl #(
    parameter int MAX_PIXELS      = ccw_pkg::MAX_PIXELS_DEF,
    parameter int MAX_CHANNELS    = ccw_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNEL_SIDE = ccw_pkg::MAX_KERNEL_SIDE_DEF,
    localparam int PAW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int COEF_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE,
    localparam int CAW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire ccw_pkg::t_mode   i_mode,
    input  wire ccw_pkg::t_cfg    i_cfg,
    output logic                  o_busy,
    output logic                  o_acc,
    output ccw_pkg::t_dp_ctl      o_ctl,
    output logic      [PAW-1:0]   o_row,
    output logic      [PAW-1:0]   o_col,
    output logic      [CAW-1:0]   o_cidx,
    output logic      [PAW-1:0]   o_pidx,
    output logic                  o_res_vld,
    output logic                  o_done
);

    // Coordinate width: holds the image sides and the kernel anchors
    localparam int FW = PAW + 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIXR,
        S_FIXC,
        S_RUN,
        S_DRAIN,
        S_WB,
        S_WBEND
    } t_state;

    t_state         r_state;
    logic [FW-1:0]  r_sr, r_sc, r_sc0, r_row, r_col;
    logic [PAW-1:0] r_x, r_pidx, r_last_p;
    logic [2:0]     r_r, r_c, r_drain;
    logic [CAW-1:0] r_cidx;
    logic           r_out_vld, r_out_done;

    logic [FW-1:0]  w_f, h_f;
    logic [25:0]    pix_cnt;
    logic           cfg_ok;
    logic           tap_first, tap_last;
    logic [FW-1:0]  n_sr, n_sc, n_row, n_col;

    function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] v,
                                               input logic [FW-1:0] lim);
        return (v == lim - FW'(1)) ? '0 : v + FW'(1);
    endfunction

    function automatic logic [FW-1:0] wrap_dec(input logic [FW-1:0] v,
                                               input logic [FW-1:0] lim);
        return (v == '0) ? lim - FW'(1) : v - FW'(1);
    endfunction

    assign w_f     = FW'(i_cfg.img_width);
    assign h_f     = FW'(i_cfg.img_height);
    assign pix_cnt = 26'(i_cfg.img_width) * 26'(i_cfg.img_height);

    // Check the configuration before a run
    assign cfg_ok = (i_cfg.img_width != '0) && (i_cfg.img_height != '0)
                 && (i_cfg.num_channels != '0)
                 && (int'(i_cfg.num_channels) <= MAX_CHANNELS)
                 && (32'(pix_cnt) <= 32'(MAX_PIXELS))
                 && ({1'b0, i_cfg.channel_sel} < i_cfg.num_channels)
                 && (i_cfg.kernel_width != '0)
                 && (int'(i_cfg.kernel_width) <= MAX_KERNEL_SIDE)
                 && (i_cfg.kernel_height != '0)
                 && (int'(i_cfg.kernel_height) <= MAX_KERNEL_SIDE)
                 && (i_cfg.center_row < i_cfg.kernel_height)
                 && (i_cfg.center_col < i_cfg.kernel_width);

    assign tap_first = (r_r == '0) && (r_c == '0);
    assign tap_last  = (r_r == i_cfg.kernel_height - 3'd1)
                    && (r_c == i_cfg.kernel_width - 3'd1);

    assign n_sr  = wrap_inc(r_sr, h_f);
    assign n_sc  = wrap_inc(r_sc, w_f);
    assign n_row = wrap_dec(r_row, h_f);
    assign n_col = wrap_dec(r_col, w_f);

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_out_done <= 1'b0;
            r_r        <= '0;
            r_c        <= '0;
            r_drain    <= '0;
            r_cidx     <= '0;
            r_pidx     <= '0;
            r_x        <= '0;
        end else begin
            r_out_vld  <= 1'b0;
            r_out_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_acc) begin
                        if (i_mode == ccw_pkg::MODE_RUN) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_out_vld <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (cfg_ok) begin
                        r_sr     <= FW'(i_cfg.center_row);
                        r_sc     <= FW'(i_cfg.center_col);
                        r_last_p <= PAW'(pix_cnt - 26'd1);
                        r_state  <= S_FIXR;
                    end else begin
                        r_out_vld  <= 1'b1;
                        r_out_done <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                // Reduce the anchor offsets modulo the image sides
                S_FIXR: begin
                    if (r_sr >= h_f) begin
                        r_sr <= r_sr - h_f;
                    end else begin
                        r_state <= S_FIXC;
                    end
                end
                S_FIXC: begin
                    if (r_sc >= w_f) begin
                        r_sc <= r_sc - w_f;
                    end else begin
                        r_sc0   <= r_sc;
                        r_row   <= r_sr;
                        r_col   <= r_sc;
                        r_x     <= '0;
                        r_pidx  <= '0;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_cidx  <= '0;
                        r_state <= S_RUN;
                    end
                end
                // Issue one kernel tap per cycle
                S_RUN: begin
                    if (tap_last) begin
                        r_r    <= '0;
                        r_c    <= '0;
                        r_cidx <= '0;
                        if (r_pidx == r_last_p) begin
                            r_drain <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_pidx <= r_pidx + PAW'(1);
                            if (FW'(r_x) == w_f - FW'(1)) begin
                                r_x   <= '0;
                                r_sr  <= n_sr;
                                r_row <= n_sr;
                                r_sc  <= r_sc0;
                                r_col <= r_sc0;
                            end else begin
                                r_x   <= r_x + PAW'(1);
                                r_sc  <= n_sc;
                                r_col <= n_sc;
                                r_row <= r_sr;
                            end
                        end
                    end else if (r_c == i_cfg.kernel_width - 3'd1) begin
                        r_c    <= '0;
                        r_col  <= r_sc;
                        r_r    <= r_r + 3'd1;
                        r_row  <= n_row;
                        r_cidx <= r_cidx + CAW'(1);
                    end else begin
                        r_c    <= r_c + 3'd1;
                        r_col  <= n_col;
                        r_cidx <= r_cidx + CAW'(1);
                    end
                end
                // Let the last sums reach the result store
                S_DRAIN: begin
                    if (r_drain == 3'(ccw_pkg::DRAIN_CYCLES - 1)) begin
                        r_pidx  <= '0;
                        r_state <= S_WB;
                    end else begin
                        r_drain <= r_drain + 3'd1;
                    end
                end
                // Copy the result plane back into the channel
                S_WB: begin
                    if (r_pidx == r_last_p) begin
                        r_state <= S_WBEND;
                    end else begin
                        r_pidx <= r_pidx + PAW'(1);
                    end
                end
                S_WBEND: begin
                    r_out_vld  <= 1'b1;
                    r_out_done <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_acc  = i_start && !o_busy;

    assign o_ctl.tap_vld   = (r_state == S_RUN);
    assign o_ctl.tap_first = tap_first;
    assign o_ctl.tap_last  = tap_last;
    assign o_ctl.wb_rd     = (r_state == S_WB);

    assign o_row     = PAW'(r_row);
    assign o_col     = PAW'(r_col);
    assign o_cidx    = r_cidx;
    assign o_pidx    = r_pidx;
    assign o_res_vld = r_out_vld;
    assign o_done    = r_out_done;

    // A non-run item answers in the next cycle without a done flag
    `ASSERT_NEXT(a_quick_item, i_clk, i_rst_n, o_acc && (i_mode != ccw_pkg::MODE_RUN), r_out_vld && !r_out_done)
    // A done flag only rides on a result strobe
    `ASSERT_IMPL(a_done_strobe, i_clk, i_rst_n, r_out_done, r_out_vld)
    // Tap issue and writeback never overlap
    `ASSERT_IMPL(a_tap_wb_excl, i_clk, i_rst_n, o_ctl.tap_vld, !o_ctl.wb_rd)

endmodule

`default_nettype wire

// ----- dv/ccw_checker.sv -----
// ---------------------------------------------------------------------------
// ccw_checker
// Watches the item, result and register ports of the convolution unit,
// predicts every result from its own copy of the stores and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module ccw_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire ccw_pkg::t_item                 i_item,
    input  wire logic                           o_res_vld,
    input  wire ccw_pkg::t_res                  o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [ccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_cnt,
    output int                                  o_pending,
    output int                                  o_run_cnt,
    output int                                  o_read_cnt
);

    localparam int IMG_BYTES  = ccw_pkg::MAX_PIXELS_DEF * ccw_pkg::MAX_CHANNELS_DEF;
    localparam int COEF_SLOTS = ccw_pkg::MAX_KERNEL_SIDE_DEF * ccw_pkg::MAX_KERNEL_SIDE_DEF;

    logic [7:0]         pix_mem [IMG_BYTES];
    logic [7:0]         plane   [ccw_pkg::MAX_PIXELS_DEF];
    logic signed [15:0] kcoef   [COEF_SLOTS];
    ccw_pkg::t_cfg      cfg;
    ccw_pkg::t_res      res_q[$];

    assign o_pending = res_q.size();

    function automatic int wrap_index(int v, int m);
        int r;
        r = v % m;
        return (r < 0) ? r + m : r;
    endfunction

    // Filter the selected channel in place; an illegal setup leaves it alone
    task automatic convolve_channel();
        int w, h, nc, sel, kw, kh, cr, cc, npix, y, x, row, col;
        longint acc, q;
        w = cfg.img_width;      h = cfg.img_height;
        nc = cfg.num_channels;  sel = cfg.channel_sel;
        kw = cfg.kernel_width;  kh = cfg.kernel_height;
        cr = cfg.center_row;    cc = cfg.center_col;
        if (w == 0 || h == 0 || nc == 0 || nc > ccw_pkg::MAX_CHANNELS_DEF) return;
        npix = w * h;
        if (npix > ccw_pkg::MAX_PIXELS_DEF || sel >= nc) return;
        if (kw == 0 || kw > ccw_pkg::MAX_KERNEL_SIDE_DEF
            || kh == 0 || kh > ccw_pkg::MAX_KERNEL_SIDE_DEF)
            return;
        if (cr >= kh || cc >= kw) return;
        for (int p = 0; p < npix; p++) begin
            y = p / w;
            x = p % w;
            acc = 0;
            for (int r = 0; r < kh; r++) begin
                row = wrap_index(y - (r - cr), h);
                for (int c = 0; c < kw; c++) begin
                    col = wrap_index(x - (c - cc), w);
                    acc += longint'(kcoef[r * kw + c]) *
                           longint'({1'b0, pix_mem[(row * w + col) * nc + sel]});
                end
            end
            if (acc < 0) begin
                plane[p] = 8'd0;
            end else begin
                q = (acc + 2048) >>> 12;
                plane[p] = (q > 255) ? 8'd255 : q[7:0];
            end
        end
        for (int p = 0; p < npix; p++) pix_mem[p * nc + sel] = plane[p];
    endtask

    // Compare delivered results, then update state from the accepted item
    always @(posedge i_clk) begin
        ccw_pkg::t_res want;
        if (!i_rst_n) begin
            foreach (pix_mem[a]) pix_mem[a] = '0;
            foreach (kcoef[a]) kcoef[a] = '0;
            cfg = '{img_width: 13'd64, img_height: 13'd64, num_channels: 3'd3,
                    channel_sel: 2'd0, kernel_width: 3'd3, kernel_height: 3'd3,
                    center_row: 3'd1, center_col: 3'd1};
            res_q.delete();
            o_fail_cnt = 0;
            o_run_cnt  = 0;
            o_read_cnt = 0;
        end else begin
            if (o_res_vld) begin
                if (res_q.size() == 0) begin
                    $error("result with no item outstanding: read_data %0d done_res %0b",
                           o_res.read_data, o_res.done_res);
                    o_fail_cnt++;
                end else begin
                    want = res_q.pop_front();
                    if (o_res.read_data !== want.read_data) begin
                        $error("read_data: expected %0d, actual %0d",
                               want.read_data, o_res.read_data);
                        o_fail_cnt++;
                    end
                    if (o_res.done_res !== want.done_res) begin
                        $error("done_res: expected %0b, actual %0b",
                               want.done_res, o_res.done_res);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (ccw_pkg::t_cfg_idx'(i_cfg_idx))
                    ccw_pkg::CFG_IMG_WIDTH:     cfg.img_width     = i_cfg_data;
                    ccw_pkg::CFG_IMG_HEIGHT:    cfg.img_height    = i_cfg_data;
                    ccw_pkg::CFG_NUM_CHANNELS:  cfg.num_channels  = i_cfg_data[2:0];
                    ccw_pkg::CFG_CHANNEL_SEL:   cfg.channel_sel   = i_cfg_data[1:0];
                    ccw_pkg::CFG_KERNEL_WIDTH:  cfg.kernel_width  = i_cfg_data[2:0];
                    ccw_pkg::CFG_KERNEL_HEIGHT: cfg.kernel_height = i_cfg_data[2:0];
                    ccw_pkg::CFG_CENTER_ROW:    cfg.center_row    = i_cfg_data[2:0];
                    ccw_pkg::CFG_CENTER_COL:    cfg.center_col    = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                want = '0;
                case (i_item.mode)
                    ccw_pkg::MODE_COEF_WR: if (i_item.address < COEF_SLOTS)
                        kcoef[i_item.address] = i_item.coef_value;
                    ccw_pkg::MODE_PIX_WR: pix_mem[i_item.address] = i_item.pixel_value;
                    ccw_pkg::MODE_RUN: begin
                        convolve_channel();
                        want.done_res = 1'b1;
                        o_run_cnt++;
                    end
                    default: begin
                        want.read_data = pix_mem[i_item.address];
                        o_read_cnt++;
                    end
                endcase
                res_q.push_back(want);
            end
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Drives the convolution unit through a series of image and kernel setups.
// ---------------------------------------------------------------------------
// Most setups load every coefficient and byte that a run or read will touch,
// then applies directed or random coefficient writes, byte writes, reads and
// runs. Register writes happen only with the unit idle. Illegal setups and
// kernels larger than the image are covered too. ccw_checker predicts.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    ccw_pkg::t_item                 i_item = '0;
    logic                           busy;
    logic                           o_res_vld;
    ccw_pkg::t_res                  o_res;
    logic                           i_cfg_we = 1'b0;
    logic [ccw_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ccw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    int                             fail_cnt, pending, run_cnt, read_cnt;

    bit   byte_ok [16384];
    int   item_cnt = 0;
    int   setup_cnt = 0;
    bit   no_gaps = 1'b0;
    int   cw, ch, cn, ckw, ckh;

    always #6 i_clk = ~i_clk;

    channel_convolution_wraparound_unit uut (
        .i_clk, .i_rst_n, .start, .i_item, .busy, .o_res_vld, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    ccw_checker u_chk (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_res_vld, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_run_cnt(run_cnt), .o_read_cnt(read_cnt)
    );

    initial begin
        #60000000;
        $display("Regression FAIL");
        $finish;
    end

    // Present one item; insert a random gap first and hold it while busy
    task automatic issue(ccw_pkg::t_mode md, int addr, int coef, int pix);
        while (!no_gaps && $urandom_range(99) < 24) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_item.mode        <= md;
        i_item.address     <= addr[13:0];
        i_item.coef_value  <= coef[15:0];
        i_item.pixel_value <= pix[7:0];
        @(negedge i_clk);
        if (md == ccw_pkg::MODE_PIX_WR) byte_ok[addr[13:0]] = 1'b1;
        item_cnt++;
    endtask

    // Drain all outstanding results, then let the unit settle
    task automatic wait_idle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(ccw_pkg::t_cfg_idx idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[ccw_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic setup(int w, int h, int nc, int sel, int kw, int kh, int cr, int cc);
        wait_idle();
        write_reg(ccw_pkg::CFG_IMG_WIDTH, w);
        write_reg(ccw_pkg::CFG_IMG_HEIGHT, h);
        write_reg(ccw_pkg::CFG_NUM_CHANNELS, nc);
        write_reg(ccw_pkg::CFG_CHANNEL_SEL, sel);
        write_reg(ccw_pkg::CFG_KERNEL_WIDTH, kw);
        write_reg(ccw_pkg::CFG_KERNEL_HEIGHT, kh);
        write_reg(ccw_pkg::CFG_CENTER_ROW, cr);
        write_reg(ccw_pkg::CFG_CENTER_COL, cc);
        @(negedge i_clk);
        cw = w; ch = h; cn = nc; ckw = kw; ckh = kh;
        setup_cnt++;
    endtask

    function automatic int rand_coef();
        case ($urandom_range(3))
            0:       return $urandom_range(65535);
            1:       return $urandom_range(1200) - 300;
            default: return $urandom_range(700);
        endcase
    endfunction

    // Load every coefficient and byte of the current frame
    task automatic load_frame();
        for (int k = 0; k < ckw * ckh; k++)
            issue(ccw_pkg::MODE_COEF_WR, k, rand_coef(), 0);
        for (int a = 0; a < cw * ch * cn; a++)
            issue(ccw_pkg::MODE_PIX_WR, a, 0, $urandom_range(255));
    endtask

    // Random traffic over the current frame
    task automatic mix(int n);
        int a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2: issue(ccw_pkg::MODE_COEF_WR, $urandom_range(31), rand_coef(), 0);
                3, 4, 5: begin
                    a = ($urandom_range(9) == 0) ? $urandom_range(16383)
                                                 : $urandom_range(cw * ch * cn - 1);
                    issue(ccw_pkg::MODE_PIX_WR, a, 0, $urandom_range(255));
                end
                6, 7, 8: begin
                    a = $urandom_range(16383);
                    if (!byte_ok[a]) a = $urandom_range(cw * ch * cn - 1);
                    issue(ccw_pkg::MODE_PIX_RD, a, 0, 0);
                end
                default: issue(ccw_pkg::MODE_RUN, $urandom_range(16383), 0, 0);
            endcase
        end
    endtask

    initial begin
        int w, h, nc, kw, kh;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Small four-channel frame, single-tap kernel: top address, rounding, clamps
        setup(8, 8, 4, 3, 1, 1, 0, 0);
        load_frame();
        issue(ccw_pkg::MODE_PIX_WR, 0, 0, 1);
        issue(ccw_pkg::MODE_PIX_WR, 16383, 0, 255);
        issue(ccw_pkg::MODE_PIX_RD, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 16383, 0, 0);
        issue(ccw_pkg::MODE_COEF_WR, 0, 16'h8000, 0);
        issue(ccw_pkg::MODE_COEF_WR, 24, 16'h7fff, 0);
        issue(ccw_pkg::MODE_COEF_WR, 25, 16'h1234, 0);
        issue(ccw_pkg::MODE_COEF_WR, 16383, 16'h5555, 0);
        issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 16383, 0, 0);
        issue(ccw_pkg::MODE_PIX_WR, 3, 0, 1);
        issue(ccw_pkg::MODE_COEF_WR, 0, 16'h0800, 0);
        issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 3, 0, 0);
        issue(ccw_pkg::MODE_COEF_WR, 0, 16'h7fff, 0);
        issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 7, 0, 0);

        // Single-row and single-column frames over the loaded bytes
        setup(64, 1, 1, 0, 1, 1, 0, 0);
        issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 63, 0, 0);
        setup(1, 64, 2, 1, 1, 2, 1, 0);
        issue(ccw_pkg::MODE_COEF_WR, 1, 16'h0400, 0);
        issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 127, 0, 0);

        // Largest kernel, last channel, far anchor
        setup(5, 5, 4, 3, 5, 5, 4, 4);
        load_frame();
        mix(60);
        // Kernel larger than the image wraps several times
        setup(3, 2, 1, 0, 5, 5, 0, 4);
        load_frame();
        mix(40);

        // Illegal setups: a run must change nothing
        setup(4, 4, 2, 3, 3, 3, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 2, 1, 6, 3, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 2, 1, 3, 7, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 2, 1, 3, 3, 5, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 2, 1, 3, 3, 1, 3);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 0, 0, 3, 3, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(4, 4, 7, 0, 3, 3, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(0, 4, 2, 0, 0, 3, 1, 1);  issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(100, 100, 1, 0, 1, 1, 0, 0); issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        setup(8191, 8191, 4, 0, 1, 1, 0, 0); issue(ccw_pkg::MODE_RUN, 0, 0, 0);
        issue(ccw_pkg::MODE_PIX_RD, 1, 0, 0);

        // Random setups with random traffic; one stretch runs without gaps
        for (int ph = 0; ph < 8; ph++) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            nc = $urandom_range(1, 4);
            kw = $urandom_range(1, 5);
            kh = $urandom_range(1, 5);
            setup(w, h, nc, $urandom_range(nc - 1), kw, kh,
                  $urandom_range(kh - 1), $urandom_range(kw - 1));
            no_gaps = (ph == 4);
            load_frame();
            mix(25);
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("Checked %0d items: %0d runs and %0d reads over %0d frame setups,",
                 item_cnt, run_cnt, read_cnt, setup_cnt);
        $display("including line frames, oversized kernels and illegal setups.");
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- channel_convolution_wraparound_unit.f -----
+incdir+design
design/ccw_pkg.sv
design/ccw_ram.sv
design/ccw_dp.sv
design/ccw_ctrl.sv
design/channel_convolution_wraparound_unit.sv
dv/ccw_checker.sv
dv/tb_top.sv
